// ----- src/emwc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helper functions of the energy meter window calculator
package emwc_pkg;

    localparam int PHASES      = 3;
    localparam int PHASE_BITS  = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 48;
    localparam int SQ_BITS     = SUM_BITS - 1;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int GAIN_BITS   = 32;
    localparam int PROD_BITS   = SUM_BITS + GAIN_BITS;
    localparam int ENERGY_BITS = 48;
    localparam int PF_BITS     = 16;
    localparam int PF_FRAC     = 14;
    localparam int IN_BITS     = 240;
    localparam int OUT_BITS    = 232;
    localparam int ADDR_BITS   = 5;

    localparam logic signed [SUM_BITS-1:0] SAMPLE_MAX = SUM_BITS'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [SUM_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - SUM_BITS'(1);

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_WINDOW_SHIFT  = 3'd0,
        REG_VOLTAGE_GAIN  = 3'd1,
        REG_CURRENT_GAIN  = 3'd2,
        REG_POWER_GAIN    = 3'd3,
        REG_ENERGY_FACTOR = 3'd4
    } emwc_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL_V,
        ST_MUL_I,
        ST_MUL_P,
        ST_MUL_S,
        ST_DIVE,
        ST_OUT
    } emwc_state_t;

    // floor mean saturated to the sample range
    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [SUM_BITS-1:0] x);
        logic signed [SUM_BITS-1:0] y;
        begin
            if (x > SAMPLE_MAX)
            begin
                y = SAMPLE_MAX;
            end
            else if (x < SAMPLE_MIN)
            begin
                y = SAMPLE_MIN;
            end
            else
            begin
                y = x;
            end
            return y[SAMPLE_BITS-1:0];
        end
    endfunction

    // product >> 8, saturated to 32 unsigned bits
    function automatic logic [31:0] sat_u32_q8(input logic [PROD_BITS-1:0] p);
        begin
            if (|p[PROD_BITS-1:40])
            begin
                return 32'hFFFF_FFFF;
            end
            return p[39:8];
        end
    endfunction

endpackage

// ----- src/emwc_isqrt.sv -----
`timescale 1ns / 1ps
// floor integer square root, two radicand bits per cycle
module emwc_isqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [emwc_pkg::SUM_BITS-1:0]      radicand,
    output logic                               busy,
    output logic [emwc_pkg::ROOT_BITS-1:0]     root
);

    localparam int REM_BITS = emwc_pkg::ROOT_BITS + 2;

    logic                              busy_reg;
    logic [4:0]                        cnt_reg;
    logic [emwc_pkg::SUM_BITS-1:0]     rad_reg;
    logic [REM_BITS-1:0]               rem_reg;
    logic [emwc_pkg::ROOT_BITS-1:0]    root_reg;
    logic [REM_BITS+1:0]               t;
    logic [REM_BITS+1:0]               trial;

    always_comb
    begin
        t     = {rem_reg, rad_reg[emwc_pkg::SUM_BITS-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(emwc_pkg::ROOT_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[emwc_pkg::SUM_BITS-3:0], 2'b00};
            if (t >= trial)
            begin
                rem_reg  <= REM_BITS'(t - trial);
                root_reg <= {root_reg[emwc_pkg::ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= t[REM_BITS-1:0];
                root_reg <= {root_reg[emwc_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- src/emwc_smul.sv -----
`timescale 1ns / 1ps
// bit-serial shift-add multiplier, one multiplier bit per cycle
module emwc_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [emwc_pkg::SUM_BITS-1:0]       a,
    input  logic [emwc_pkg::GAIN_BITS-1:0]      b,
    output logic                                busy,
    output logic [emwc_pkg::PROD_BITS-1:0]      prod
);

    logic                               busy_reg;
    logic [4:0]                         cnt_reg;
    logic [emwc_pkg::SUM_BITS-1:0]      a_reg;
    logic [emwc_pkg::GAIN_BITS-1:0]     b_reg;
    logic [emwc_pkg::SUM_BITS-1:0]      hi_reg;
    logic [emwc_pkg::GAIN_BITS-1:0]     lo_reg;
    logic [emwc_pkg::SUM_BITS:0]        sum;

    assign sum = {1'b0, hi_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(emwc_pkg::GAIN_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= {1'b0, b_reg[emwc_pkg::GAIN_BITS-1:1]};
            hi_reg <= sum[emwc_pkg::SUM_BITS:1];
            lo_reg <= {sum[0], lo_reg[emwc_pkg::GAIN_BITS-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ----- src/emwc_pfdiv.sv -----
`timescale 1ns / 1ps
// power factor magnitude: restoring divide of active over apparent power, one bit per cycle
module emwc_pfdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] apmag,
    input  logic [31:0] apparent,
    output logic        busy,
    output logic [14:0] quot
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [14:0] bits_reg;
    logic [14:0] q_reg;
    logic [32:0] t;
    logic [32:0] twice;

    assign t     = {rem_reg, bits_reg[14]};
    assign twice = {apparent, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            // zero apparent power and ratios of two or more need no iterations
            busy_reg <= (apparent != 32'd0) && ({1'b0, apmag} < twice);
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd14)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= apparent;
            rem_reg  <= {1'b0, apmag[31:1]};
            bits_reg <= {apmag[0], 14'd0};
            if (apparent == 32'd0)
            begin
                q_reg <= '0;
            end
            else if ({1'b0, apmag} >= twice)
            begin
                q_reg <= 15'd16384;
            end
            else
            begin
                q_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            bits_reg <= {bits_reg[13:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                rem_reg <= 32'(t - {1'b0, div_reg});
                q_reg   <= {q_reg[13:0], 1'b1};
            end
            else
            begin
                rem_reg <= t[31:0];
                q_reg   <= {q_reg[13:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = (q_reg > 15'd16384) ? 15'd16384 : q_reg;

endmodule

// ----- src/energy_meter_window_calc_top.sv -----
`timescale 1ns / 1ps
// sequence: from input transfer to result, both square roots run side by side, then the
// shared bit-serial multiplier makes five passes (divide hidden under the last), and
// then the output register is loaded
// flow: one item at a time, a new transfer is taken once the previous result is in
// the output register; an item for a missing phase is taken and dropped
// reset: asynchronous active low, shift 8 and unity gains, energy totals clear to zero at once
module energy_meter_window_calc_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // phase, sum_v, sum_i, sum_v_sq, sum_i_sq, sum_p (lowest bit up)
    input  logic [emwc_pkg::IN_BITS-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phase_out, v_offset, i_offset, v_rms, i_rms, active_power, apparent_power,
    // energy, power_factor (lowest bit up), zero padded
    output logic [emwc_pkg::OUT_BITS-1:0]      m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [emwc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // configuration registers
    logic [3:0]  window_shift_reg;
    logic [31:0] voltage_gain_reg;
    logic [31:0] current_gain_reg;
    logic [31:0] power_gain_reg;
    logic [31:0] energy_factor_reg;
    emwc_pkg::emwc_reg_t reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = emwc_pkg::emwc_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_shift_reg  <= 4'd8;
            voltage_gain_reg  <= 32'd65536;
            current_gain_reg  <= 32'd65536;
            power_gain_reg    <= 32'd65536;
            energy_factor_reg <= 32'd65536;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                emwc_pkg::REG_WINDOW_SHIFT:  window_shift_reg  <= pwdata[3:0];
                emwc_pkg::REG_VOLTAGE_GAIN:  voltage_gain_reg  <= pwdata;
                emwc_pkg::REG_CURRENT_GAIN:  current_gain_reg  <= pwdata;
                emwc_pkg::REG_POWER_GAIN:    power_gain_reg    <= pwdata;
                emwc_pkg::REG_ENERGY_FACTOR: energy_factor_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            emwc_pkg::REG_WINDOW_SHIFT:  prdata = {28'd0, window_shift_reg};
            emwc_pkg::REG_VOLTAGE_GAIN:  prdata = voltage_gain_reg;
            emwc_pkg::REG_CURRENT_GAIN:  prdata = current_gain_reg;
            emwc_pkg::REG_POWER_GAIN:    prdata = power_gain_reg;
            emwc_pkg::REG_ENERGY_FACTOR: prdata = energy_factor_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    // input field unpacking
    logic [1:0]                                in_phase;
    logic signed [emwc_pkg::SUM_BITS-1:0]      in_sum_v;
    logic signed [emwc_pkg::SUM_BITS-1:0]      in_sum_i;
    logic [emwc_pkg::SQ_BITS-1:0]              in_sum_v_sq;
    logic [emwc_pkg::SQ_BITS-1:0]              in_sum_i_sq;
    logic signed [emwc_pkg::SUM_BITS-1:0]      in_sum_p;

    assign in_phase    = s_tdata[1:0];
    assign in_sum_v    = s_tdata[49:2];
    assign in_sum_i    = s_tdata[97:50];
    assign in_sum_v_sq = s_tdata[144:98];
    assign in_sum_i_sq = s_tdata[191:145];
    assign in_sum_p    = s_tdata[239:192];

    // means: arithmetic shift gives floor rounding
    logic signed [emwc_pkg::SUM_BITS-1:0] mean_v;
    logic signed [emwc_pkg::SUM_BITS-1:0] mean_i;
    logic signed [emwc_pkg::SUM_BITS-1:0] mean_p;
    logic [emwc_pkg::SUM_BITS-1:0]        rad_v;
    logic [emwc_pkg::SUM_BITS-1:0]        rad_i;

    assign mean_v = in_sum_v >>> window_shift_reg;
    assign mean_i = in_sum_i >>> window_shift_reg;
    assign mean_p = in_sum_p >>> window_shift_reg;
    assign rad_v  = {1'b0, in_sum_v_sq} >> window_shift_reg;
    assign rad_i  = {1'b0, in_sum_i_sq} >> window_shift_reg;

    // sequencer
    emwc_pkg::emwc_state_t state_reg, state_next;
    logic accept;
    logic phase_ok;
    logic sqrt_start;
    logic mul_start;
    logic div_start;
    logic [emwc_pkg::SUM_BITS-1:0]  mul_a;
    logic [emwc_pkg::GAIN_BITS-1:0] mul_b;

    logic                                   sq_v_busy, sq_i_busy;
    logic [emwc_pkg::ROOT_BITS-1:0]         root_v, root_i;
    logic                                   mul_busy;
    logic [emwc_pkg::PROD_BITS-1:0]         mul_prod;
    logic                                   div_busy;
    logic [14:0]                            div_quot;

    // captured item and intermediate results
    logic [1:0]                             phase_reg;
    logic [emwc_pkg::SAMPLE_BITS-1:0]       v_off_reg, i_off_reg;
    logic [emwc_pkg::SUM_BITS-1:0]          mag_reg;
    logic                                   neg_reg;
    logic [31:0]                            vr_reg, ir_reg, ap_reg, apmag_reg, s_reg;
    logic [emwc_pkg::ENERGY_BITS-1:0]       energy_reg;
    logic signed [emwc_pkg::ENERGY_BITS-1:0] energy_total_reg [emwc_pkg::PHASES];

    logic                                   m_tvalid_reg;
    logic [emwc_pkg::OUT_BITS-1:0]          m_tdata_reg;

    assign s_tready = (state_reg == emwc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign phase_ok = (in_phase < 2'(emwc_pkg::PHASES));

    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            emwc_pkg::ST_IDLE:
            begin
                // an item for a phase that does not exist is dropped
                if (accept && phase_ok)
                begin
                    sqrt_start = 1'b1;
                    state_next = emwc_pkg::ST_SQRT;
                end
            end
            emwc_pkg::ST_SQRT:
            begin
                if (!sq_v_busy && !sq_i_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = emwc_pkg::SUM_BITS'(root_v);
                    mul_b      = voltage_gain_reg;
                    state_next = emwc_pkg::ST_MUL_V;
                end
            end
            emwc_pkg::ST_MUL_V:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = emwc_pkg::SUM_BITS'(root_i);
                    mul_b      = current_gain_reg;
                    state_next = emwc_pkg::ST_MUL_I;
                end
            end
            emwc_pkg::ST_MUL_I:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mag_reg;
                    mul_b      = power_gain_reg;
                    state_next = emwc_pkg::ST_MUL_P;
                end
            end
            emwc_pkg::ST_MUL_P:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_a      = emwc_pkg::SUM_BITS'(vr_reg);
                    mul_b      = ir_reg;
                    state_next = emwc_pkg::ST_MUL_S;
                end
            end
            emwc_pkg::ST_MUL_S:
            begin
                // energy product and power factor divide run side by side
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    div_start  = 1'b1;
                    mul_a      = emwc_pkg::SUM_BITS'(apmag_reg);
                    mul_b      = energy_factor_reg;
                    state_next = emwc_pkg::ST_DIVE;
                end
            end
            emwc_pkg::ST_DIVE:
            begin
                if (!mul_busy && !div_busy)
                begin
                    state_next = emwc_pkg::ST_OUT;
                end
            end
            emwc_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = emwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = emwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result shaping from the multiplier output
    logic [31:0]  sat_q8;
    logic [71:0]  p_full;
    logic [31:0]  p_r;
    logic [31:0]  p_apmag;
    logic [46:0]  efm;
    logic signed [emwc_pkg::ENERGY_BITS+1:0] e_inc;
    logic signed [emwc_pkg::ENERGY_BITS+1:0] e_sum;
    logic signed [emwc_pkg::ENERGY_BITS-1:0] e_tot;
    logic [emwc_pkg::PF_BITS-1:0]           pf;

    assign sat_q8 = emwc_pkg::sat_u32_q8(mul_prod);

    always_comb
    begin
        // active power magnitude clamps at 2^31 before the sign is applied
        p_full = mul_prod[79:8];
        if ((|p_full[71:32]) || (p_full[31] && (|p_full[30:0])))
        begin
            p_r = 32'h8000_0000;
        end
        else
        begin
            p_r = p_full[31:0];
        end
        if (!neg_reg && p_r[31])
        begin
            p_apmag = 32'h7FFF_FFFF;
        end
        else
        begin
            p_apmag = p_r;
        end

        // energy increment, magnitude truncated toward zero, total saturating
        efm   = mul_prod[62:16];
        e_inc = neg_reg ? -$signed({3'b000, efm}) : $signed({3'b000, efm});
        e_sum = $signed({{2{energy_total_reg[phase_reg][47]}}, energy_total_reg[phase_reg]})
                + e_inc;
        if (e_sum[49:47] == 3'b000 || e_sum[49:47] == 3'b111)
        begin
            e_tot = e_sum[47:0];
        end
        else if (e_sum[49])
        begin
            e_tot = {1'b1, 47'd0};
        end
        else
        begin
            e_tot = {1'b0, {47{1'b1}}};
        end

        pf = neg_reg ? 16'(-{1'b0, div_quot}) : {1'b0, div_quot};
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_ok)
        begin
            phase_reg <= in_phase;
            v_off_reg <= emwc_pkg::sat_sample(mean_v);
            i_off_reg <= emwc_pkg::sat_sample(mean_i);
            neg_reg   <= mean_p[emwc_pkg::SUM_BITS-1];
            mag_reg   <= mean_p[emwc_pkg::SUM_BITS-1] ? 48'(-mean_p) : mean_p;
        end
        if (state_reg == emwc_pkg::ST_MUL_V && !mul_busy)
        begin
            vr_reg <= sat_q8;
        end
        if (state_reg == emwc_pkg::ST_MUL_I && !mul_busy)
        begin
            ir_reg <= sat_q8;
        end
        if (state_reg == emwc_pkg::ST_MUL_P && !mul_busy)
        begin
            apmag_reg <= p_apmag;
            ap_reg    <= neg_reg ? 32'(-p_r) : p_apmag;
        end
        if (state_reg == emwc_pkg::ST_MUL_S && !mul_busy)
        begin
            s_reg <= sat_q8;
        end
        if (state_reg == emwc_pkg::ST_DIVE && !mul_busy && !div_busy)
        begin
            energy_reg <= e_tot;
        end
    end

    // per-phase energy totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < emwc_pkg::PHASES; k++)
            begin
                energy_total_reg[k] <= '0;
            end
        end
        else if (state_reg == emwc_pkg::ST_DIVE && !mul_busy && !div_busy)
        begin
            energy_total_reg[phase_reg] <= e_tot;
        end
    end

    // output register parts the sequencer from the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == emwc_pkg::ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == emwc_pkg::ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {6'd0, pf, energy_reg, s_reg, ap_reg, ir_reg, vr_reg,
                            i_off_reg, v_off_reg, phase_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the two root lanes run in lockstep
    emwc_isqrt u_sqrt_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_v),
        .busy     (sq_v_busy),
        .root     (root_v)
    );

    emwc_isqrt u_sqrt_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_i),
        .busy     (sq_i_busy),
        .root     (root_i)
    );

    // shared multiplier: gains, active power, apparent power, energy
    emwc_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    emwc_pfdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .apmag    (apmag_reg),
        .apparent (sat_q8),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    a_roots_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emwc_pkg::ST_SQRT) |-> (sq_v_busy == sq_i_busy))
        else $error("square root lanes out of step");

    a_bad_phase_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !phase_ok) |=> (state_reg == emwc_pkg::ST_IDLE))
        else $error("item for missing phase was processed");

    a_div_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emwc_pkg::ST_DIVE && !mul_busy) |-> !div_busy)
        else $error("divider outlasted energy multiply");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emwc_pkg::ST_IDLE) |-> (!mul_busy && !div_busy && !sq_v_busy))
        else $error("unit busy while sequencer idle");

endmodule
